// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, defaults and controller/datapath handshake types for the
// buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int ADDR_W = 22;             // byte address and request width
	localparam int HDR_W  = 7;              // header size register width
	localparam int TOT_W  = ADDR_W + 1;     // request plus header
	localparam int TDATA_W = 24;            // address padded to whole bytes

	localparam int                BBA_PAGE_ORDER = 12;
	localparam int                BBA_NUM_PAGES  = 1024;
	localparam logic [HDR_W-1:0]  HDR_RESET      = HDR_W'(32);

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // capture request, form total
		logic eval;     // classify, search free orders, claim block or pages
		logic split;    // peel one lower half off onto its order list
		logic emit;     // move result into the output register
	} bba_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic split_go;     // eval leaves halves to split
		logic split_last;   // current split step is the final one
		logic out_free;     // output register can take a result this cycle
	} bba_sts_t;

endpackage

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: load, evaluate, split down one order per
// cycle, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bba_ctrl
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  bba_sts_t sts,
	output bba_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_SPLIT = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.split_go ? ST_SPLIT : ST_DONE;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				if (sts.split_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: header register, page counter, per-order free list,
// split walker and the output register.
// ----------------------------------------------------------------------------
module bba_dp
	import bba_pkg::*;
#(
	parameter int PAGE_ORDER = BBA_PAGE_ORDER,
	parameter int NUM_PAGES  = BBA_NUM_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [HDR_W-1:0]   cfg_data,
	input  logic [TDATA_W-1:0] s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tuser,
	input  bba_cmd_t           cmd,
	output bba_sts_t           sts
);

	localparam int ORD_W = $clog2(PAGE_ORDER + 1);
	localparam int PG_W  = $clog2(NUM_PAGES + 1);
	localparam int CNT_W = TOT_W + 1 - PAGE_ORDER;
	localparam int CMP_W = ((CNT_W > PG_W) ? CNT_W : PG_W) + 1;
	localparam logic [TOT_W-1:0] PAGE_BYTES = TOT_W'(1) << PAGE_ORDER;
	localparam logic [TOT_W:0]   PAGE_MASK  = (TOT_W + 1)'(PAGE_BYTES) - 1'b1;
	localparam logic [PG_W-1:0]  PAGES_ALL  = PG_W'(NUM_PAGES);
	localparam logic [ORD_W-1:0] ORD_TOP    = ORD_W'(PAGE_ORDER);

	logic [HDR_W-1:0]  hdr_q;
	logic [TOT_W-1:0]  total_q;
	logic [PG_W-1:0]   npi_q;
	logic [PAGE_ORDER:0] valid_q;
	logic [ADDR_W-1:0] fadr_q [PAGE_ORDER+1];
	logic [ORD_W-1:0]  k_q;
	logic [ORD_W-1:0]  i_q;
	logic [ADDR_W-1:0] blk_q;
	logic              err_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_err_q;

	logic                      big;
	logic [TOT_W:0]            tot_up;
	logic [CNT_W-1:0]          cnt;
	logic [CMP_W-1:0]          left;
	logic                      big_err;
	logic                      small_err;
	logic                      err;
	logic [TOT_W-1:0]          tot_m1;
	logic [ORD_W-1:0]          k_c;
	logic                      found;
	logic [ORD_W-1:0]          j_c;
	logic [ORD_W-1:0]          j_eff;
	logic [PG_W+PAGE_ORDER-1:0] pg_full;
	logic [ADDR_W-1:0]         pg_base;
	logic [ORD_W-1:0]          i_n;

	// multi-page requests: ceiling page count against what the pool has left
	assign big     = total_q > PAGE_BYTES;
	assign tot_up  = {1'b0, total_q} + PAGE_MASK;
	assign cnt     = tot_up[TOT_W:PAGE_ORDER];
	assign left    = CMP_W'(PAGES_ALL) - CMP_W'(npi_q);
	assign big_err = CMP_W'(cnt) > left;
	assign pg_full = {npi_q, {PAGE_ORDER{1'b0}}};
	assign pg_base = ADDR_W'(pg_full);

	// order = ceil(log2 total); totals of 0 or 1 give order 0
	assign tot_m1 = total_q - 1'b1;
	always_comb begin
		k_c = '0;
		if (total_q > TOT_W'(1)) begin
			for (int b = 0; b < PAGE_ORDER; b++) begin
				if (tot_m1[b])
					k_c = ORD_W'(b + 1);
			end
		end
	end

	// lowest free order at or above k
	always_comb begin
		found = 1'b0;
		j_c   = '0;
		for (int b = PAGE_ORDER; b >= 0; b--) begin
			if (valid_q[b] && ORD_W'(b) >= k_c) begin
				found = 1'b1;
				j_c   = ORD_W'(b);
			end
		end
	end

	assign j_eff     = found ? j_c : ORD_TOP;
	assign small_err = !found && (npi_q == PAGES_ALL);
	assign err       = big ? big_err : small_err;
	assign i_n       = i_q - 1'b1;

	assign sts.split_go   = !err && !big && (j_eff > k_c);
	assign sts.split_last = (i_q == k_q + 1'b1);
	assign sts.out_free   = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= HDR_RESET;
			npi_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				hdr_q <= cfg_data;
			if (cmd.eval && !err) begin
				if (big) begin
					npi_q <= npi_q + PG_W'(cnt);
				end else if (found) begin
					valid_q[j_c] <= 1'b0;
				end else begin
					npi_q <= npi_q + 1'b1;
				end
			end
			if (cmd.split)
				valid_q[i_n] <= 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			total_q <= TOT_W'(s_axis_tdata[ADDR_W-1:0]) + TOT_W'(hdr_q);
		if (cmd.eval) begin
			err_q <= err;
			k_q   <= k_c;
			i_q   <= j_eff;
			if (big || !found)
				blk_q <= pg_base;
			else
				blk_q <= fadr_q[j_c];
		end
		// walk down from the top: each lower half sits right after the last
		if (cmd.split) begin
			fadr_q[i_n] <= blk_q;
			blk_q       <= blk_q + (ADDR_W'(1) << i_n);
			i_q         <= i_n;
		end
		if (cmd.emit) begin
			out_err_q  <= err_q;
			out_addr_q <= err_q ? '0 : blk_q + ADDR_W'(hdr_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_addr_q);
	assign m_axis_tuser  = out_err_q;

endmodule

// ===== hdl/buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Allocation-only binary buddy allocator over a pool of fresh pages.
//
// s_axis carries one request per beat (tdata[21:0] = request_bytes). m_axis
// returns one result beat per request: tdata[21:0] = address (block start
// plus header), tuser = status (1 when the page pool is exhausted, address
// then reads 0). cfg writes the header size; cfg_ready is always high and a
// write is meant only while no request is in flight.
//
// A request is loaded on acceptance, evaluated, then split down from order j
// (the order split from) to order k (the order requested) before it reaches
// the result register; multi-page requests and exact order hits need no split.
// The split walker peels one order per cycle. The next request is accepted
// the cycle after the current one has been placed in the output register, so
// a new request is not taken while one is in flight; one result may wait
// while the next is worked on, and a stalled receiver keeps the second
// finished result waiting with the sequencer held in its done state.
// Reset empties every order list, rewinds the page counter to zero and sets
// the header size to 32 bytes.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int PAGE_ORDER = BBA_PAGE_ORDER,
	parameter int NUM_PAGES  = BBA_NUM_PAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [HDR_W-1:0]   cfg_data,       // header_bytes
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // [21:0] request_bytes, [23:22] zero
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [21:0] address, [23:22] zero
	output logic               m_axis_tuser    // [0] status
);

	bba_cmd_t cmd;
	bba_sts_t sts;

	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	bba_dp #(
		.PAGE_ORDER (PAGE_ORDER),
		.NUM_PAGES  (NUM_PAGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cmd           (cmd),
		.sts           (sts)
	);

	// a result never lands on one the receiver has not taken
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

	// an accepted beat is evaluated in the very next cycle
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (cmd.eval && !s_axis_tready))
		else $error("accepted beat not evaluated");

	// one command at a time
	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.eval, cmd.split, cmd.emit}))
		else $error("overlapping commands");

	// the split walker stops after its last step
	a_split_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.split && sts.split_last) |=> !cmd.split)
		else $error("split ran past requested order");

endmodule

// ===== tb/buddy_block_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit_test
// Self-checking bench for the buddy block allocator. Requests go in on s_axis
// in random bursts and results are taken from m_axis under a changing stall
// pattern. A tracker class keeps its own copy of the order lists, the page
// counter and the header size. It predicts the address and status of every
// accepted request and checks each result beat against them in order. The
// run covers directed corner requests and random mixes under several header
// sizes, then uses up the page pool and checks the exhausted results.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_test;
	import bba_pkg::*;

	localparam int  PAGE_ORDER = BBA_PAGE_ORDER;
	localparam int  NUM_PAGES  = BBA_NUM_PAGES;
	localparam int  PAGE_BYTES = 1 << PAGE_ORDER;
	localparam int  HDR_MAX    = 64;
	localparam int  PHASE_ITEMS = 115;

	typedef struct {
		logic [ADDR_W-1:0] address;
		logic              status;
	} grant_t;

	class buddy_alloc_tracker;
		grant_t            pending_grants[$];
		logic [HDR_W-1:0]  header;
		bit                free_valid[PAGE_ORDER+1];
		logic [ADDR_W-1:0] free_addr[PAGE_ORDER+1];
		int                next_page;
		int                mismatches;
		int                requests;
		int                grants;
		int                exhausted;

		function new();
			header     = HDR_RESET;
			next_page  = 0;
			mismatches = 0;
			requests   = 0;
			grants     = 0;
			exhausted  = 0;
			foreach (free_valid[i]) begin
				free_valid[i] = 1'b0;
				free_addr[i]  = '0;
			end
		endfunction

		function int pages_left();
			return NUM_PAGES - next_page;
		endfunction

		// Works out the grant for one request and updates the lists and page count.
		function grant_t predict_grant(logic [ADDR_W-1:0] req);
			longint total;
			longint count;
			longint base;
			longint block;
			int     k;
			int     j;
			grant_t g;
			g.address = '0;
			g.status  = 1'b1;
			total = longint'(req) + longint'(header);
			if (total > PAGE_BYTES) begin
				count = (total + PAGE_BYTES - 1) >> PAGE_ORDER;
				if (count > longint'(NUM_PAGES - next_page))
					return g;
				base = longint'(next_page) << PAGE_ORDER;
				next_page += int'(count);
				block = base;
			end else begin
				k = 0;
				while (k < PAGE_ORDER && (longint'(1) << k) < total)
					k++;
				j = k;
				while (j <= PAGE_ORDER && !free_valid[j])
					j++;
				if (j > PAGE_ORDER) begin
					if (next_page >= NUM_PAGES)
						return g;
					base = longint'(next_page) << PAGE_ORDER;
					next_page++;
					j = PAGE_ORDER;
				end else begin
					base = longint'(free_addr[j]);
					free_valid[j] = 1'b0;
				end
				// lower halves of the split chain go onto their order lists
				for (int i = k; i < j; i++) begin
					free_addr[i]  = ADDR_W'(base + (longint'(1) << j) - (longint'(1) << (i + 1)));
					free_valid[i] = 1'b1;
				end
				block = base + (longint'(1) << j) - (longint'(1) << k);
			end
			g.address = ADDR_W'(block + longint'(header));
			g.status  = 1'b0;
			return g;
		endfunction

		function void note_request(logic [ADDR_W-1:0] req);
			pending_grants.push_back(predict_grant(req));
			requests++;
		endfunction

		function void check_grant(logic [ADDR_W-1:0] address, logic status);
			grant_t g;
			if (pending_grants.size() == 0) begin
				$error("unexpected result beat: address 0x%06h status %0d", address, status);
				mismatches++;
				return;
			end
			g = pending_grants.pop_front();
			grants++;
			if (g.status)
				exhausted++;
			if (address !== g.address) begin
				$error("address mismatch: expected 0x%06h, actual 0x%06h", g.address, address);
				mismatches++;
			end
			if (status !== g.status) begin
				$error("status mismatch: expected %0d, actual %0d", g.status, status);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [HDR_W-1:0]   cfg_data;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;    // [21:0] request_bytes, [23:22] zero
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;    // [21:0] address, [23:22] zero
	logic               m_axis_tuser;    // [0] status

	buddy_alloc_tracker tracker;
	int                 burst_left;
	int                 stall_pct;
	int                 rx_cycles;
	int                 header_writes;

	buddy_block_allocator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: stall rate is redrawn from 0, 25, 60 or 90 percent, zero included
	always @(posedge clk) begin
		if (rx_cycles % 256 == 0) begin
			case ($urandom_range(0, 4))
				0, 1: begin
					stall_pct = 0;
				end
				2: begin
					stall_pct = 25;
				end
				3: begin
					stall_pct = 60;
				end
				default: begin
					stall_pct = 90;
				end
			endcase
		end
		rx_cycles++;
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_grant(m_axis_tdata[ADDR_W-1:0], m_axis_tuser);
	end

	task automatic send_request(input logic [ADDR_W-1:0] req);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(req);
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_request(req);
		burst_left--;
	endtask

	// drain all outstanding beats, then allow for a worst-case split walk
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_grants.size() != 0)
			@(posedge clk);
		repeat (PAGE_ORDER + 6) @(posedge clk);
	endtask

	task automatic write_header(input logic [HDR_W-1:0] h);
		wait_idle();
		cfg_data  <= h;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.header = h;
		header_writes++;
	endtask

	function automatic logic [ADDR_W-1:0] random_request();
		int     pick;
		int     k;
		int     n;
		longint total;
		pick = $urandom_range(0, 99);
		// far too many pages: always refused once a few pages are gone
		if (pick < 3 && tracker.next_page > 16)
			return ADDR_W'($urandom_range(32'h3F0000, 32'h3FFFFF));
		if (pick < 15 && tracker.pages_left() > 40) begin
			n = $urandom_range(2, 12);
			if ($urandom_range(0, 3) == 0)
				total = longint'(n) * PAGE_BYTES;
			else
				total = longint'(n - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
		end else begin
			k = $urandom_range(0, PAGE_ORDER);
			if (k == 0)
				total = $urandom_range(0, 1);
			else
				total = $urandom_range((1 << (k - 1)) + 1, 1 << k);
		end
		return (total > tracker.header) ? ADDR_W'(total - tracker.header) : '0;
	endfunction

	initial begin
		automatic logic [HDR_W-1:0] phase_hdr[4];
		int n;
		int total;
		tracker       = new();
		burst_left    = 0;
		stall_pct     = 0;
		rx_cycles     = 0;
		header_writes = 0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		phase_hdr[0]  = HDR_W'(HDR_MAX);
		phase_hdr[1]  = HDR_W'(1);
		phase_hdr[2]  = HDR_W'($urandom_range(0, HDR_MAX));
		phase_hdr[3]  = HDR_W'(32);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, header at its reset size
		send_request(22'd0);          // long split from a fresh page
		send_request(22'd0);          // exact hit on a free order
		send_request(22'd1);
		send_request(22'd31);
		send_request(22'd2016);       // hits the top free half
		send_request(22'd4064);       // one whole page
		send_request(22'd4065);       // just over a page
		send_request(22'd8160);       // exact two-page multiple
		send_request(22'h3FFFFF);     // more than the whole pool
		write_header(HDR_W'(0));
		send_request(22'd0);          // empty total
		send_request(22'd1);
		send_request(22'd2);
		send_request(22'd3);
		send_request(22'd4096);
		send_request(22'd12288);
		send_request(22'h3FFFFF);
		write_header(HDR_W'(63));
		send_request(22'd1);
		send_request(22'd4033);
		send_request(22'h2AAAAA);
		send_request(22'h155555);

		foreach (phase_hdr[p]) begin
			write_header(phase_hdr[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_request(random_request());
		end

		// use up the pool, leaving one page for the wrap-around case
		write_header(HDR_W'(HDR_MAX));
		while (tracker.pages_left() > 1) begin
			n = tracker.pages_left() - 1;
			if (n > 40)
				n = $urandom_range(2, 40);
			if (n == 1)
				total = PAGE_BYTES;
			else if ($urandom_range(0, 3) == 0)
				total = n * PAGE_BYTES;
			else
				total = (n - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
			send_request(ADDR_W'(total - HDR_MAX));
		end
		// last page at the top of the address space, then exhaustion
		for (int i = 0; i < 24; i++)
			send_request(22'd0);
		for (int i = 0; i < 20; i++)
			send_request(random_request());

		wait_idle();
		$display("Run: %0d requests over %0d header settings, %0d results checked.",
			tracker.requests, header_writes + 1, tracker.grants);
		$display("Pool: %0d of %0d pages claimed, %0d requests refused as exhausted.",
			tracker.next_page, NUM_PAGES, tracker.exhausted);
		if (tracker.mismatches == 0 && tracker.pending_grants.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
